@@ rtl/rre_pkg.sv @@
// Shared types, constants and word-expansion functions for the rotating-escape RLE encoder.
package rre_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] RESET_ESCAPE_START = 8'h55;
	localparam logic [BYTE_W-1:0] RESET_ESCAPE_STEP = 8'h3B;
	localparam logic [BYTE_W-1:0] RUN_LIMIT_COUNT = 8'd254;
	localparam logic [BYTE_W-1:0] LONG_RUN_COUNT = 8'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_STEP = 2'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic last_of_item;
		logic stream_done;
	} out_item_t;

	typedef enum logic [1:0] {
		RUN_NONE,
		RUN_LIT,
		RUN_TRIPLE
	} run_kind_t;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_SINGLE,
		TAIL_DOUBLE
	} tail_kind_t;

	// One queued command: an optional run part, then an optional tail part.
	typedef struct packed {
		run_kind_t run_kind;
		logic [BYTE_W-1:0] run_esc;
		logic [BYTE_W-1:0] run_byte;
		logic [BYTE_W-1:0] run_len;
		tail_kind_t tail_kind;
		logic [BYTE_W-1:0] tail_byte;
		logic eos;
	} cmd_t;

	function automatic logic [IDX_W-1:0] run_words(input cmd_t c);
		logic [IDX_W-1:0] n;
		case (c.run_kind)
			RUN_LIT: n = c.run_len[IDX_W-1:0];
			RUN_TRIPLE: n = IDX_W'(3);
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [IDX_W-1:0] cmd_len(input cmd_t c);
		logic [IDX_W-1:0] t;
		case (c.tail_kind)
			TAIL_SINGLE: t = IDX_W'(1);
			TAIL_DOUBLE: t = IDX_W'(2);
			default: t = '0;
		endcase
		return run_words(c) + t;
	endfunction

	function automatic logic [BYTE_W-1:0] cmd_byte(input cmd_t c, input logic [IDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		if (idx < run_words(c)) begin
			if (c.run_kind == RUN_TRIPLE) begin
				case (idx)
					IDX_W'(0): b = c.run_esc;
					IDX_W'(1): b = c.run_byte;
					default: b = c.run_len;
				endcase
			end else begin
				b = c.run_byte;
			end
		end else begin
			b = c.tail_byte;
		end
		return b;
	endfunction

endpackage

@@ rtl/rre_front.sv @@
// Front end: config registers, run/escape state and command classification per input word.
module rre_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rre_pkg::BYTE_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  rre_pkg::in_item_t in_item,
	input  logic full,
	output logic push,
	output rre_pkg::cmd_t cmd
);
	import rre_pkg::*;

	logic [BYTE_W-1:0] escape_start_q, escape_step_q;
	logic [BYTE_W-1:0] held_byte_q, repeat_count_q, escape_value_q;
	logic window_empty_q, stream_idle_q;

	logic [BYTE_W-1:0] held_d, cnt_d, esc_d;
	logic empty_d;
	logic [BYTE_W-1:0] esc, esc_rot, esc_rot2, cnt_inc, b;
	logic long_run, accept;

	assign in_stall = full;
	assign accept = in_valid && !full;
	assign push = accept && (cmd_len(cmd) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_start_q <= RESET_ESCAPE_START;
			escape_step_q <= RESET_ESCAPE_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ESCAPE_START: escape_start_q <= cfg_data;
				CFG_ESCAPE_STEP: escape_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		b = in_item.in_byte;
		esc = stream_idle_q ? escape_start_q : escape_value_q;
		esc_rot = esc + escape_step_q;
		esc_rot2 = esc_rot + escape_step_q;
		long_run = !window_empty_q && (repeat_count_q >= LONG_RUN_COUNT);
		cnt_inc = repeat_count_q + 8'd1;

		cmd.run_kind = RUN_NONE;
		cmd.run_esc = esc;
		cmd.run_byte = held_byte_q;
		cmd.run_len = cnt_inc;
		cmd.tail_kind = TAIL_NONE;
		cmd.tail_byte = b;
		cmd.eos = in_item.end_of_stream;
		held_d = held_byte_q;
		cnt_d = repeat_count_q;
		empty_d = window_empty_q;
		esc_d = esc;

		if (b == esc) begin
			if (long_run) begin
				cmd.run_kind = RUN_TRIPLE;
				if (b == esc_rot) begin
					cmd.tail_kind = TAIL_DOUBLE;
					esc_d = esc_rot2;
				end else begin
					cmd.tail_kind = TAIL_SINGLE;
					esc_d = esc_rot;
				end
			end else begin
				cmd.run_kind = window_empty_q ? RUN_NONE : RUN_LIT;
				cmd.tail_kind = TAIL_DOUBLE;
				esc_d = esc_rot;
			end
			cnt_d = '0;
			empty_d = 1'b1;
		end else if (window_empty_q) begin
			held_d = b;
			cnt_d = '0;
			empty_d = 1'b0;
		end else if (b == held_byte_q) begin
			if (cnt_inc >= RUN_LIMIT_COUNT) begin
				// run limit reached: emit the triple now and empty the window
				cmd.run_kind = RUN_TRIPLE;
				cmd.run_len = cnt_inc + 8'd1;
				esc_d = esc_rot;
				cnt_d = '0;
				empty_d = 1'b1;
			end else begin
				cnt_d = cnt_inc;
			end
		end else begin
			if (long_run) begin
				cmd.run_kind = RUN_TRIPLE;
			end else begin
				cmd.run_kind = RUN_LIT;
			end
			if (b == (long_run ? esc_rot : esc)) begin
				cmd.tail_kind = TAIL_DOUBLE;
				esc_d = long_run ? esc_rot2 : esc_rot;
				cnt_d = '0;
				empty_d = 1'b1;
			end else begin
				esc_d = long_run ? esc_rot : esc;
				held_d = b;
				cnt_d = '0;
				empty_d = 1'b0;
			end
		end

		if (in_item.end_of_stream) begin
			// flush whatever the window still holds, then return to reset
			if (!empty_d) begin
				if (cmd.run_kind == RUN_NONE) begin
					cmd.run_esc = esc_d;
					cmd.run_byte = held_d;
					cmd.run_len = cnt_d + 8'd1;
					cmd.run_kind = (cnt_d >= LONG_RUN_COUNT) ? RUN_TRIPLE : RUN_LIT;
				end else begin
					cmd.tail_kind = TAIL_SINGLE;
					cmd.tail_byte = held_d;
				end
			end
			held_d = '0;
			cnt_d = '0;
			empty_d = 1'b1;
			esc_d = escape_start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q <= '0;
			repeat_count_q <= '0;
			window_empty_q <= 1'b1;
			escape_value_q <= RESET_ESCAPE_START;
			stream_idle_q <= 1'b1;
		end else if (accept) begin
			held_byte_q <= held_d;
			repeat_count_q <= cnt_d;
			window_empty_q <= empty_d;
			escape_value_q <= esc_d;
			stream_idle_q <= in_item.end_of_stream;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.end_of_stream) |=> (stream_idle_q && window_empty_q))
		else $error("stream end did not return state to reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		!window_empty_q |-> (repeat_count_q < RUN_LIMIT_COUNT))
		else $error("held run exceeds run limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.end_of_stream) |-> push)
		else $error("stream end produced no words");

endmodule

@@ rtl/rre_cmd_queue.sv @@
// Small register FIFO of commands between front and back.
module rre_cmd_queue #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rre_pkg::cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output rre_pkg::cmd_t head
);
	import rre_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty command queue");

endmodule

@@ rtl/rre_back.sv @@
// Back end: expands each command into encoded words through a registered output stage.
module rre_back (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  rre_pkg::cmd_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output rre_pkg::out_item_t out_item
);
	import rre_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic out_valid_q;
	out_item_t out_item_q;
	logic load, last;

	assign last = (idx_q == cmd_len(head) - IDX_W'(1));
	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop = load && last;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q.out_byte <= cmd_byte(head, idx_q);
			out_item_q.last_of_item <= last;
			out_item_q.stream_done <= last && head.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= head_valid;
			end
			// advance through the command, wrap on its last word
			if (load) begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < cmd_len(head)))
		else $error("word index past end of command");

	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> head_valid)
		else $error("command left queue mid-expansion");

endmodule

@@ rtl/rle_rotating_escape_encoder_core.sv @@
// Top level of the rotating-escape run-length encoder.
// Byte-stream RLE encoder: runs of 4..255 equal bytes become (escape, byte, length), a raw
// byte equal to the escape is sent twice, and each escape use adds escape_step to the escape.
// The front end takes one input word per cycle and queues a command holding 0..5 output
// words; the back end drains one output word per cycle, unless out_stall holds it, through
// a registered output stage. The front stalls only when the QUEUE_DEPTH-entry command
// queue is full. An item's words pass through the command queue and then the registered
// output stage. Write escape_start (index 0) and escape_step (index 1) only while the
// block is idle; writes to other indexes are ignored, and a new escape_start applies from
// the next stream.
module rle_rotating_escape_encoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rre_pkg::BYTE_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  rre_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output rre_pkg::out_item_t out_item
);
	import rre_pkg::*;

	logic push, full, pop, head_valid;
	cmd_t push_cmd, head;

	rre_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.full(full),
		.push(push),
		.cmd(push_cmd)
	);

	rre_cmd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	rre_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

endmodule

@@ bench/tb_rle_rotating_escape_encoder_core.sv @@
// Self-checking bench for the rotating-escape run-length encoder core.
`timescale 1ns / 1ps

module tb_rle_rotating_escape_encoder_core;
	import rre_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 24;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	rle_rotating_escape_encoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// Encoder state as the bench sees it.
	logic [BYTE_W-1:0] esc_start_r = RESET_ESCAPE_START;
	logic [BYTE_W-1:0] esc_step_r = RESET_ESCAPE_STEP;
	logic [BYTE_W-1:0] held_b = '0;
	logic [BYTE_W-1:0] run_count = '0;
	logic [BYTE_W-1:0] esc_now = RESET_ESCAPE_START;
	bit window_clear = 1'b1;
	bit between_streams = 1'b1;
	logic [BYTE_W-1:0] step_bytes[$];

	out_item_t enc_words_q[$];
	out_item_t want_w;

	int mismatch_count = 0;
	int words_checked = 0;
	int bytes_sent = 0;
	int streams_ended = 0;
	int cycle_count = 0;
	int send_gap_max = 4;
	int stall_gap_max = 4;
	int drain_hold = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycle_count,
				enc_words_q.size());
			$display("rle_rotating_escape_encoder_core: mismatch");
			$finish;
		end
	end

	function automatic logic [BYTE_W-1:0] live_escape();
		return between_streams ? esc_start_r : esc_now;
	endfunction

	function automatic void advance_escape();
		esc_now = esc_now + esc_step_r;
	endfunction

	function automatic void put_doubled_escape();
		step_bytes.push_back(esc_now);
		step_bytes.push_back(esc_now);
		advance_escape();
	endfunction

	// Emit the held run as literals or as an escape triple; empty the window.
	function automatic void flush_held_run();
		if (run_count >= LONG_RUN_COUNT) begin
			step_bytes.push_back(esc_now);
			step_bytes.push_back(held_b);
			step_bytes.push_back(run_count + 8'd1);
			advance_escape();
		end else begin
			for (int k = 0; k <= int'(run_count); k++)
				step_bytes.push_back(held_b);
		end
		run_count = '0;
		window_clear = 1'b1;
	endfunction

	function automatic void encode_byte(input in_item_t it);
		logic [BYTE_W-1:0] b;
		out_item_t w;
		int n;
		b = it.in_byte;
		step_bytes.delete();
		if (between_streams) begin
			esc_now = esc_start_r;
			between_streams = 1'b0;
		end
		if (b == esc_now) begin
			if (!window_clear && run_count >= LONG_RUN_COUNT) begin
				flush_held_run();
				if (b == esc_now)
					put_doubled_escape();
				else
					step_bytes.push_back(b);
			end else begin
				if (!window_clear)
					flush_held_run();
				put_doubled_escape();
			end
			window_clear = 1'b1;
		end else if (window_clear) begin
			held_b = b;
			run_count = '0;
			window_clear = 1'b0;
		end else if (b == held_b) begin
			run_count++;
			if (run_count >= RUN_LIMIT_COUNT)
				flush_held_run();
		end else begin
			flush_held_run();
			if (b == esc_now) begin
				put_doubled_escape();
			end else begin
				held_b = b;
				window_clear = 1'b0;
			end
		end
		if (it.end_of_stream) begin
			if (!window_clear)
				flush_held_run();
			held_b = '0;
			run_count = '0;
			window_clear = 1'b1;
			esc_now = esc_start_r;
			between_streams = 1'b1;
		end
		n = (step_bytes.size() > 5) ? 5 : step_bytes.size();
		for (int k = 0; k < n; k++) begin
			w.out_byte = step_bytes[k];
			w.last_of_item = (k == n - 1);
			w.stream_done = (k == n - 1) && it.end_of_stream;
			enc_words_q.push_back(w);
		end
	endfunction

	// Check every accepted output word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (enc_words_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %02h/%b/%b", $time,
					out_item.out_byte, out_item.last_of_item, out_item.stream_done);
				mismatch_count++;
			end else begin
				want_w = enc_words_q.pop_front();
				words_checked++;
				if (out_item.out_byte !== want_w.out_byte) begin
					$display("%0t: out_byte expected %02h, got %02h", $time,
						want_w.out_byte, out_item.out_byte);
					mismatch_count++;
				end
				if (out_item.last_of_item !== want_w.last_of_item) begin
					$display("%0t: last_of_item expected %b, got %b", $time,
						want_w.last_of_item, out_item.last_of_item);
					mismatch_count++;
				end
				if (out_item.stream_done !== want_w.stream_done) begin
					$display("%0t: stream_done expected %b, got %b", $time,
						want_w.stream_done, out_item.stream_done);
					mismatch_count++;
				end
			end
		end
	end

	// Output side: random stall before each word, plus an occasional long hold.
	initial begin : drain_side
		int gap;
		int n;
		@(posedge arst_n);
		forever begin
			if (drain_hold > 0) begin
				n = drain_hold;
				drain_hold = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			gap = $urandom_range(0, stall_gap_max);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit eos);
		in_item_t it;
		int gap;
		it.in_byte = b;
		it.end_of_stream = eos;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		encode_byte(it);
		bytes_sent++;
		if (eos)
			streams_ended++;
	endtask

	task automatic send_run(input logic [BYTE_W-1:0] b, input int len, input bit eos);
		for (int k = 0; k < len; k++)
			send_byte(b, eos && (k == len - 1));
	endtask

	// Drop valid, let every predicted word drain, then give the core time to go idle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (enc_words_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_escape(input logic [BYTE_W-1:0] start, input logic [BYTE_W-1:0] step);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ESCAPE_START;
		cfg_data <= start;
		@(posedge clk);
		esc_start_r = start;
		cfg_index <= CFG_ESCAPE_STEP;
		cfg_data <= step;
		@(posedge clk);
		esc_step_r = step;
		cfg_we <= 1'b0;
	endtask

	// Segments of short runs, long runs, escape bytes and noise; some end a stream.
	task automatic send_random_mix(input int n_items);
		int sent;
		int kind;
		int len;
		logic [BYTE_W-1:0] b;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 39);
			b = BYTE_W'($urandom);
			if (kind < 14)
				len = $urandom_range(1, 3);
			else if (kind < 24)
				len = $urandom_range(4, 12);
			else if (kind < 30) begin
				len = $urandom_range(1, 2);
				b = live_escape();
			end else if (kind < 34) begin
				len = 1;
				b = live_escape() + esc_step_r;
			end else if (kind < 39)
				len = 1;
			else
				len = $urandom_range(13, 24);
			send_run(b, len, $urandom_range(0, 5) == 0);
			sent += len;
		end
	endtask

	// Reset values: escape 0x55, step 0x3B.
	task automatic test_literals_and_escapes();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h55, 1'b1);
		send_run(8'h12, 2, 1'b0);
		send_run(8'h34, 3, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h90, 1'b1);
		wait_drained();
	endtask

	task automatic test_long_runs();
		send_run(8'hAA, 4, 1'b0);
		// escape ends a long run; the triple rotates it, so it goes out once
		send_byte(8'h55, 1'b0);
		send_run(8'hAA, 5, 1'b1);
		wait_drained();
	endtask

	task automatic test_escape_after_run();
		set_escape(8'hFF, 8'h00);
		send_run(8'h01, 4, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_run(8'h00, 5, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_drained();
		set_escape(8'h10, 8'h20);
		// byte that ends the run equals the rotated escape
		send_run(8'h33, 4, 1'b0);
		send_byte(8'h30, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_escape_loading();
		set_escape(8'h55, 8'h3B);
		send_byte(8'h01, 1'b0);
		wait_drained();
		// new start value waits for the next stream
		set_escape(8'h20, 8'hFF);
		send_byte(8'h55, 1'b1);
		send_byte(8'h20, 1'b1);
		wait_drained();
	endtask

	task automatic test_run_limit();
		set_escape(8'h00, 8'h01);
		send_run(8'h42, 255, 1'b0);
		send_run(8'h42, 3, 1'b1);
		wait_drained();
	endtask

	task automatic test_backpressure();
		set_escape(8'h80, 8'h80);
		send_gap_max = 0;
		drain_hold = 150;
		send_random_mix(40);
		send_gap_max = 4;
		wait_drained();
	endtask

	task automatic test_random_streams();
		logic [BYTE_W-1:0] starts[5];
		logic [BYTE_W-1:0] steps[5];
		starts = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
		steps = '{8'hFF, 8'h01, 8'h00, 8'h00, 8'h00};
		starts[2] = BYTE_W'($urandom);
		steps[2] = BYTE_W'($urandom);
		starts[3] = BYTE_W'($urandom);
		starts[4] = BYTE_W'($urandom);
		steps[4] = BYTE_W'($urandom);
		for (int p = 0; p < 5; p++) begin
			set_escape(starts[p], steps[p]);
			// one phase runs back to back on both sides
			send_gap_max = (p == 2) ? 0 : 4;
			stall_gap_max = (p == 2) ? 0 : 4;
			send_random_mix(12);
			send_byte(BYTE_W'($urandom), 1'b1);
			wait_drained();
		end
		send_gap_max = 4;
		stall_gap_max = 4;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ESCAPE_START;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_item <= '0;
		out_stall <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_literals_and_escapes();
		test_long_runs();
		test_escape_after_run();
		test_escape_loading();
		test_run_limit();
		test_backpressure();
		test_random_streams();
		wait_drained();

		$display("sent %0d bytes in %0d streams, checked %0d encoded words", bytes_sent,
			streams_ended, words_checked);
		$display("escape steps 0, 1, 0x80, 0xFF and random; run limit and long stall hit");
		if (mismatch_count == 0) begin
			$display("rle_rotating_escape_encoder_core: match");
		end else begin
			$display("rle_rotating_escape_encoder_core: mismatch");
		end
		$finish;
	end

endmodule
